// File: design/stereo_gain_fade_channel_mixer_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stereo gain/fade mixer
// Wraps concurrent checks so that synthesis sees an empty body.
// ---------------------------------------------------------------------------
`ifndef STEREO_GAIN_FADE_CHANNEL_MIXER_CORE_MACROS_SVH
`define STEREO_GAIN_FADE_CHANNEL_MIXER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SGFM_ASSERT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("mixer check failed");
// next-cycle implication
`define SGFM_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("mixer check failed");
`else
`define SGFM_ASSERT(label, clk, rst, pre, post)
`define SGFM_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// File: design/sgfm_pkg.sv
// ---------------------------------------------------------------------------
// sgfm_pkg
// Types, codes and constants shared by the stereo gain/fade mixer.
// ---------------------------------------------------------------------------
package sgfm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PCT_W       = 7;   // 0..100
  localparam int SCALE_W     = 14;  // gain * fade, up to 10000
  localparam int PROD_W      = 29;  // |sample| * scale < 2^29
  localparam int RECIP_W     = 30;
  localparam int FULL_W      = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = 43;  // exact /10000 for 29-bit dividends

  localparam logic [RECIP_W-1:0] RECIP_10K = 30'd879609303;

  // fade = elapsed * 100 / 180 = (elapsed * 5 * 7282) >> 16 for elapsed < 180
  localparam int FADE_MS        = 180;
  localparam int FADE_PROD_W    = 24;
  localparam int FADE_SHIFT     = 16;
  localparam logic [15:0] FADE_RECIP = 16'd36410;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_85   = 7'd85;
  localparam logic [PCT_W-1:0] PCT_70   = 7'd70;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_ENABLED = 3'd0,
    REG_CHANNEL_MODE   = 3'd1,
    REG_GAIN_PRESET    = 3'd2,
    REG_STARTUP_FADE   = 3'd3,
    REG_FADE_START_MS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SWAP   = 2'd1,
    MODE_MONO   = 2'd2
  } chan_mode_t;

  typedef enum logic [1:0] {
    GAIN_FULL = 2'd0,
    GAIN_85   = 2'd1,
    GAIN_70   = 2'd2
  } gain_code_t;

  // per-stage load strobes handed to the sample lanes
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld6;
  } adv_t;

  function automatic logic [PCT_W-1:0] gain_pct(input logic [1:0] preset);
    logic [PCT_W-1:0] pct;
    case (preset)
      GAIN_FULL: pct = PCT_FULL;
      GAIN_85:   pct = PCT_85;
      default:   pct = PCT_70;   // unused code behaves like 70 percent
    endcase
    return pct;
  endfunction

endpackage

// File: design/sgfm_frame_if.sv
// ---------------------------------------------------------------------------
// sgfm_frame_if
// Input frame channel: stereo samples, buffer time stamp, end-of-buffer flag.
// ---------------------------------------------------------------------------
interface sgfm_frame_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  left_in;
  logic signed [15:0]  right_in;
  logic        [31:0]  now_ms;
  logic                buffer_end;

  modport source (output valid, output left_in, output right_in, output now_ms,
                  output buffer_end, input ready);
  modport sink   (input valid, input left_in, input right_in, input now_ms,
                  input buffer_end, output ready);
endinterface

// File: design/sgfm_result_if.sv
// ---------------------------------------------------------------------------
// sgfm_result_if
// Result channel: processed stereo samples and end-of-buffer copy.
// ---------------------------------------------------------------------------
interface sgfm_result_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  left_out;
  logic signed [15:0]  right_out;
  logic                buffer_last;

  modport source (output valid, output left_out, output right_out,
                  output buffer_last, input ready);
  modport sink   (input valid, input left_out, input right_out,
                  input buffer_last, output ready);
endinterface

// File: design/sgfm_cfg_if.sv
// ---------------------------------------------------------------------------
// sgfm_cfg_if
// Register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface sgfm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sgfm_pkg::CFG_IDX_W-1:0]    index;
  logic [sgfm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/sgfm_lane.sv
// ---------------------------------------------------------------------------
// sgfm_lane
// One channel's scaling path: |sample| * scale, exact divide by 10000 via
// reciprocal multiply, sign restore. Stages 2 through 6 of the pipeline.
// ---------------------------------------------------------------------------
module sgfm_lane (
  input  logic                              clk,
  input  sgfm_pkg::adv_t                    adv,
  input  logic [sgfm_pkg::SAMPLE_W-1:0]     mag_s1,
  input  logic                              neg_s1,
  input  logic [sgfm_pkg::SCALE_W-1:0]      scale_s3,
  output logic signed [sgfm_pkg::SAMPLE_W-1:0] sample_out
);
  import sgfm_pkg::*;

  logic [SAMPLE_W-1:0] mag2, mag3;
  logic                neg2, neg3, neg4, neg5;
  logic [PROD_W-1:0]   prod4;
  logic [SAMPLE_W-1:0] quo5;
  logic [FULL_W-1:0]   full_prod;

  assign full_prod = FULL_W'(prod4) * FULL_W'(RECIP_10K);

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      mag2 <= mag_s1;
      neg2 <= neg_s1;
    end
    if (adv.ld3) begin
      mag3 <= mag2;
      neg3 <= neg2;
    end
    if (adv.ld4) begin
      prod4 <= PROD_W'(mag3) * PROD_W'(scale_s3);
      neg4  <= neg3;
    end
    if (adv.ld5) begin
      // quotient never exceeds 32768, so 16 bits hold it
      quo5 <= full_prod[RECIP_SHIFT +: SAMPLE_W];
      neg5 <= neg4;
    end
    if (adv.ld6) begin
      sample_out <= neg5 ? -$signed(quo5) : $signed(quo5);
    end
  end

endmodule

// File: design/stereo_gain_fade_channel_mixer_core.sv
// ---------------------------------------------------------------------------
// stereo_gain_fade_channel_mixer_core
// Stereo PCM mixer: channel mode, preset gain and startup fade-in.
// An accepted frame passes through the stage registers in order to its result beat.
// Throughput: one frame per cycle while the result side is ready; stages stall individually, bubbles fill.
// Stage 5 holds the 29x30 reciprocal multiply that sets the cycle time.
// Reset clears all stage valid bits and loads register defaults.
// ---------------------------------------------------------------------------
`include "stereo_gain_fade_channel_mixer_core_macros.svh"

module stereo_gain_fade_channel_mixer_core (
  input  logic  clk,
  input  logic  rst,
  sgfm_frame_if.sink   frame,
  sgfm_result_if.source result,
  sgfm_cfg_if.sink     cfg
);
  import sgfm_pkg::*;

  localparam int NSTG = 6;

  // configuration
  logic              output_enabled;
  logic [1:0]        channel_mode;
  logic [1:0]        gain_preset;
  logic              startup_fade;
  logic [TIME_W-1:0] fade_start_ms;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enabled <= 1'b1;
      channel_mode   <= MODE_NORMAL;
      gain_preset    <= GAIN_FULL;
      startup_fade   <= 1'b0;
      fade_start_ms  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OUTPUT_ENABLED: output_enabled <= cfg.data[0];
        REG_CHANNEL_MODE:   channel_mode   <= cfg.data[1:0];
        REG_GAIN_PRESET:    gain_preset    <= cfg.data[1:0];
        REG_STARTUP_FADE:   startup_fade   <= cfg.data[0];
        REG_FADE_START_MS:  fade_start_ms  <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // stage control
  logic [NSTG:1] v;
  logic [NSTG:1] ld;
  adv_t          adv;

  always_comb begin
    ld[NSTG] = !v[NSTG] || result.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign frame.ready = ld[1];
  assign adv = '{ld2: ld[2], ld3: ld[3], ld4: ld[4], ld5: ld[5], ld6: ld[6]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      // disabled output: the beat is taken and dropped here
      if (ld[1]) v[1] <= frame.valid && output_enabled;
      for (int k = 2; k <= NSTG; k++) begin
        if (ld[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: channel routing, magnitudes, elapsed time
  logic signed [SAMPLE_W:0]   pair_sum;
  logic signed [SAMPLE_W-1:0] mono;
  logic signed [SAMPLE_W-1:0] sel_l, sel_r;
  logic [TIME_W-1:0]          elapsed;
  logic                       in_win;

  assign pair_sum = {frame.left_in[SAMPLE_W-1], frame.left_in} +
                    {frame.right_in[SAMPLE_W-1], frame.right_in};
  // round toward zero: bump every negative sum by one before the shift
  assign mono = SAMPLE_W'((pair_sum + (SAMPLE_W+1)'(pair_sum[SAMPLE_W])) >>> 1);

  always_comb begin
    case (channel_mode)
      MODE_SWAP: begin
        sel_l = frame.right_in;
        sel_r = frame.left_in;
      end
      MODE_MONO: begin
        sel_l = mono;
        sel_r = mono;
      end
      default: begin
        sel_l = frame.left_in;
        sel_r = frame.right_in;
      end
    endcase
  end

  assign elapsed = frame.now_ms - fade_start_ms;
  assign in_win  = startup_fade && (elapsed < TIME_W'(FADE_MS));

  logic [SAMPLE_W-1:0] mag_l1, mag_r1;
  logic                neg_l1, neg_r1;
  logic [7:0]          elap1;
  logic                win1;
  logic [PCT_W-1:0]    gain1, gain2;
  logic [PCT_W-1:0]    fade2;
  logic [SCALE_W-1:0]  scale3;
  logic [NSTG:1]       last;
  logic [FADE_PROD_W-1:0] fade_prod;

  assign fade_prod = FADE_PROD_W'(elap1) * FADE_PROD_W'(FADE_RECIP);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      neg_l1  <= sel_l[SAMPLE_W-1];
      neg_r1  <= sel_r[SAMPLE_W-1];
      mag_l1  <= sel_l[SAMPLE_W-1] ? SAMPLE_W'(-sel_l) : SAMPLE_W'(sel_l);
      mag_r1  <= sel_r[SAMPLE_W-1] ? SAMPLE_W'(-sel_r) : SAMPLE_W'(sel_r);
      elap1   <= elapsed[7:0];
      win1    <= in_win;
      gain1   <= gain_pct(gain_preset);
      last[1] <= frame.buffer_end;
    end
    if (ld[2]) begin
      fade2   <= win1 ? fade_prod[FADE_SHIFT +: PCT_W] : PCT_FULL;
      gain2   <= gain1;
      last[2] <= last[1];
    end
    if (ld[3]) begin
      scale3  <= SCALE_W'(gain2) * SCALE_W'(fade2);
      last[3] <= last[2];
    end
    for (int k = 4; k <= NSTG; k++) begin
      if (ld[k]) last[k] <= last[k-1];
    end
  end

  sgfm_lane u_lane_l (
    .clk        (clk),
    .adv        (adv),
    .mag_s1     (mag_l1),
    .neg_s1     (neg_l1),
    .scale_s3   (scale3),
    .sample_out (result.left_out)
  );

  sgfm_lane u_lane_r (
    .clk        (clk),
    .adv        (adv),
    .mag_s1     (mag_r1),
    .neg_s1     (neg_r1),
    .scale_s3   (scale3),
    .sample_out (result.right_out)
  );

  assign result.valid       = v[NSTG];
  assign result.buffer_last = last[NSTG];

  `SGFM_ASSERT(a_full_stall, clk, rst, (&v) && !result.ready, !frame.ready)
  `SGFM_ASSERT(a_empty_entry, clk, rst, !v[1], frame.ready)
  `SGFM_ASSERT_NEXT(a_drop_disabled, clk, rst, frame.valid && frame.ready && !output_enabled, !v[1])
  `SGFM_ASSERT_NEXT(a_feed_out, clk, rst, v[NSTG-1] && ld[NSTG], v[NSTG])

endmodule

// File: tb/tb_stereo_gain_fade_channel_mixer_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stereo_gain_fade_channel_mixer_core
// Self-checking bench for the stereo gain/fade mixer. Frames go in on the
// frame channel, and every result beat is checked against a local model
// that tracks the register settings. The bench covers register defaults,
// sample extremes, all channel modes and gain presets, the startup fade
// window and its 32-bit wrap, and output gating. It then runs random
// buffers with idle bursts on both sides and ends with a full-rate stream.
// ---------------------------------------------------------------------------
module tb_stereo_gain_fade_channel_mixer_core;
  import sgfm_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int FADE_WINDOW  = 180;
  localparam int FULL_SCALE   = 10000;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] GAIN_SPARE = 2'd3;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } mixed_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgfm_frame_if  frame_ch ();
  sgfm_result_if result_ch ();
  sgfm_cfg_if    cfg_ch ();

  stereo_gain_fade_channel_mixer_core uut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // register shadow
  logic        out_en;
  logic [1:0]  mix_mode;
  logic [1:0]  gain_sel;
  logic        fade_on;
  logic [31:0] fade_base;

  mixed_frame_t pending_mix [$];
  int err_count      = 0;
  int frames_sent    = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  bit src_idle_on    = 1'b1;
  bit sink_idle_on   = 1'b1;
  int stall_left     = 0;

  function automatic bit mix_frame(input logic signed [15:0] l, input logic signed [15:0] r,
                                   input logic [31:0] now, input logic last,
                                   output mixed_frame_t res);
    logic [31:0] elapsed;
    int fade;
    int gain;
    int scale;
    int mono;
    int lo;
    int ro;
    if (!out_en) return 1'b0;
    elapsed = now - fade_base;
    if (fade_on && elapsed < FADE_WINDOW)
      fade = int'((elapsed * 32'd100) / FADE_WINDOW);
    else
      fade = 100;
    case (gain_sel)
      GAIN_FULL: gain = 100;
      GAIN_85:   gain = 85;
      default:   gain = 70;
    endcase
    scale = gain * fade;
    case (mix_mode)
      MODE_SWAP: begin
        lo = (int'(r) * scale) / FULL_SCALE;
        ro = (int'(l) * scale) / FULL_SCALE;
      end
      MODE_MONO: begin
        mono = (int'(l) + int'(r)) / 2;
        lo = (mono * scale) / FULL_SCALE;
        ro = lo;
      end
      default: begin
        lo = (int'(l) * scale) / FULL_SCALE;
        ro = (int'(r) * scale) / FULL_SCALE;
      end
    endcase
    res.left  = lo[15:0];
    res.right = ro[15:0];
    res.last  = last;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("%0t mismatch: %s", $time, msg);
    err_count++;
  endtask

  // sink side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    mixed_frame_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_mix.size() == 0) begin
        report_mismatch($sformatf("result beat L=%0d R=%0d with nothing pending",
                                  result_ch.left_out, result_ch.right_out));
      end else begin
        want = pending_mix.pop_front();
        results_seen++;
        if (result_ch.left_out !== want.left)
          report_mismatch($sformatf("left_out %0d, want %0d", result_ch.left_out, want.left));
        if (result_ch.right_out !== want.right)
          report_mismatch($sformatf("right_out %0d, want %0d", result_ch.right_out,
                                    want.right));
        if (result_ch.buffer_last !== want.last)
          report_mismatch($sformatf("buffer_last %0b, want %0b", result_ch.buffer_last,
                                    want.last));
      end
    end
  end

  task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r,
                            input logic [31:0] now, input logic last);
    mixed_frame_t res;
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      frame_ch.valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.left_in    <= l;
    frame_ch.right_in   <= r;
    frame_ch.now_ms     <= now;
    frame_ch.buffer_end <= last;
    do @(posedge clk); while (!frame_ch.ready);
    frames_sent++;
    if (mix_frame(l, r, now, last, res)) pending_mix.push_back(res);
    @(negedge clk);
  endtask

  // wait for every pending result, then let dropped frames clear the pipe
  task automatic settle();
    frame_ch.valid <= 1'b0;
    while (pending_mix.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic en, input logic [1:0] mode,
                                input logic [1:0] gain, input logic fade,
                                input logic [31:0] start);
    cfg_reg_t    regs [5];
    logic [31:0] vals [5];
    regs = '{REG_OUTPUT_ENABLED, REG_CHANNEL_MODE, REG_GAIN_PRESET, REG_STARTUP_FADE,
             REG_FADE_START_MS};
    vals = '{{31'd0, en}, {30'd0, mode}, {30'd0, gain}, {31'd0, fade}, start};
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (regs[i])
        REG_OUTPUT_ENABLED: out_en    = vals[i][0];
        REG_CHANNEL_MODE:   mix_mode  = vals[i][1:0];
        REG_GAIN_PRESET:    gain_sel  = vals[i][1:0];
        REG_STARTUP_FADE:   fade_on   = vals[i][0];
        REG_FADE_START_MS:  fade_base = vals[i];
        default: ;
      endcase
      reg_writes++;
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 16) - 8);
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_now(input logic [31:0] start);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return start + 32'($urandom_range(0, 199));
      5:             return start - 32'($urandom_range(1, 50));
      default:       return 32'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_frame(16'sd1000, -16'sd1000, 32'd5, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 32'd77, 1'b1);
    send_frame(-16'sd1, 16'sd1, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_sample_extremes();
    settle();
    apply_settings(1'b1, MODE_NORMAL, GAIN_70, 1'b0, 32'd0);
    send_frame(16'sh8000, 16'sh7FFF, 32'd0, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 32'd1, 1'b0);
    send_frame(-16'sd1, -16'sd1, 32'd2, 1'b1);
  endtask

  task automatic test_channel_modes();
    logic [1:0] modes [4];
    modes = '{MODE_NORMAL, MODE_SWAP, MODE_MONO, MODE_SPARE};
    foreach (modes[i]) begin
      settle();
      apply_settings(1'b1, modes[i], GAIN_85, 1'b0, 32'd0);
      // odd negative sums check the mono truncation toward zero
      send_frame(16'sh8000, 16'sd32765, 32'd10, 1'b0);
      send_frame(16'sh8000, 16'sh8001, 32'd10, 1'b1);
    end
  endtask

  task automatic test_gain_presets();
    logic [1:0] gains [4];
    gains = '{GAIN_FULL, GAIN_85, GAIN_70, GAIN_SPARE};
    foreach (gains[i]) begin
      settle();
      apply_settings(1'b1, MODE_NORMAL, gains[i], 1'b0, 32'd0);
      send_frame(16'sh8000, 16'sh7FFF, 32'd3, 1'b1);
    end
  endtask

  task automatic test_fade_window();
    logic [31:0] start;
    start = 32'hFFFF_FFF0;
    settle();
    apply_settings(1'b1, MODE_NORMAL, GAIN_FULL, 1'b1, start);
    send_frame(16'sh7FFF, 16'sh8000, start, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, start + 32'd1, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, start + 32'd90, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, start + 32'd179, 1'b1);   // time wrapped past zero
    send_frame(16'sh7FFF, 16'sh8000, start + 32'd180, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, start - 32'd1, 1'b1);     // huge elapsed, full level
  endtask

  task automatic test_output_disabled();
    settle();
    apply_settings(1'b0, MODE_SWAP, GAIN_70, 1'b1, 32'hFFFF_FFFF);
    send_frame(16'sd1234, -16'sd4321, 32'hFFFF_FFFF, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 32'd0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int counted;
    int phase_target;
    int phase_count;
    int blen;
    logic [31:0] start;
    logic [31:0] now;
    logic en;
    logic sloppy;
    counted = 0;
    while (counted < 440) begin
      settle();
      en = ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 3))
        0:       start = 32'd0;
        1:       start = 32'hFFFF_FFFF;
        default: start = 32'($urandom);
      endcase
      apply_settings(en, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), start);
      phase_target = $urandom_range(30, 70);
      phase_count  = 0;
      while (phase_count < phase_target) begin
        // one buffer: shared time stamp, end flag on its last beat (random end flags when sloppy)
        blen   = $urandom_range(1, 8);
        now    = pick_now(start);
        sloppy = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < blen; k++)
          send_frame(pick_sample(), pick_sample(), now,
                     sloppy ? 1'($urandom_range(0, 1)) : 1'(k == blen - 1));
        phase_count += blen;
        counted += blen;
      end
    end
  endtask

  task automatic test_full_rate_stream();
    logic [31:0] start;
    settle();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    start = 32'($urandom);
    apply_settings(1'b1, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b1, start);
    for (int k = 0; k < 50; k++)
      send_frame(pick_sample(), pick_sample(), start + 32'(k * 4), 1'(k % 5 == 4));
  endtask

  initial begin
    frame_ch.valid      = 1'b0;
    frame_ch.left_in    = '0;
    frame_ch.right_in   = '0;
    frame_ch.now_ms     = '0;
    frame_ch.buffer_end = 1'b0;
    result_ch.ready     = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_OUTPUT_ENABLED;
    cfg_ch.data         = '0;
    out_en    = 1'b1;
    mix_mode  = MODE_NORMAL;
    gain_sel  = GAIN_FULL;
    fade_on   = 1'b0;
    fade_base = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_sample_extremes();
    test_channel_modes();
    test_gain_presets();
    test_fade_window();
    test_output_disabled();
    test_random_traffic();
    test_full_rate_stream();
    settle();

    $display("frames sent %0d, result beats checked %0d, register writes %0d",
             frames_sent, results_seen, reg_writes);
    $display("modes 0-3, presets 0-3, fade window with wrap, output gating; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("[stereo_gain_fade_channel_mixer_core] OK");
    end else begin
      $display("[stereo_gain_fade_channel_mixer_core] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", pending_mix.size());
    $display("[stereo_gain_fade_channel_mixer_core] ERROR");
    $finish;
  end

endmodule
